// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and controller/datapath interface types of the first-fit
// heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NULL    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// source of the result offset
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_PTR  = 2'd1,
		RES_TAKE = 2'd2
	} res_sel_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_WALK_INIT,
		OP_READ_WALK,
		OP_STEP,
		OP_LATCH_CUR,
		OP_LATCH_TAKE,
		OP_READ_NEXT,
		OP_CLEAR_NEXT,
		OP_LATCH_NEXT,
		OP_WRITE_MERGE,
		OP_WRITE_TAKE,
		OP_WRITE_SPLIT,
		OP_FINISH
	} dp_op_t;

	// command from controller to datapath
	typedef struct packed {
		dp_op_t   op;
		status_t  st;
		res_sel_t sel;
		logic     copy;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] act;
		logic       req_zero;
		logic       ptr_zero;
		logic       at_end;
		logic       hit;
		logic       rd_free;
		logic       fits;
		logic       keep;
		logic       split;
		logic       next_end;
	} dp_flags_t;

endpackage

`default_nettype wire

// ===== hdl/first_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with split and coalesce over an address-ordered
// chain of block headers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: action, pointer_offset
//   and request_size. Output channel (out_valid/out_stall) returns one result
//   item per input item: status, result_offset, copy_source, copy_length.
//   One item is worked on at a time; in_stall is high from acceptance until
//   the result is placed in the output register.
//   Each header visited by a walk takes a memory read, then an evaluate
//   step, since the header memory read is registered. A moving resize
//   walks the chain up to three times. Null frees, zero-size allocates
//   and the unused action code go straight to the result.
//   The result register lets the next item be accepted while a result waits;
//   if the receiver stalls, the block holds the following result until the
//   register is free.
//   Reset (arst_n low) empties the heap to one free block at once; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES    = 262144,
	parameter int GRANULE_BYTES = 8,
	parameter int HEADER_BYTES  = 24,
	localparam int PW = $clog2(HEAP_BYTES),
	localparam int RW = PW + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    action,
	input  wire logic [PW-1:0] pointer_offset,
	input  wire logic [RW-1:0] request_size,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         status,
	output logic [PW-1:0]      result_offset,
	output logic [PW-1:0]      copy_source,
	output logic [RW-1:0]      copy_length
);

	ffha_pkg::cmd_t      cmd;
	ffha_pkg::dp_flags_t flags;

	// sequencer
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// header memory and arithmetic
	ffha_dp #(
		.HEAP_BYTES    (HEAP_BYTES),
		.GRANULE_BYTES (GRANULE_BYTES),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.flags          (flags),
		.action         (action),
		.pointer_offset (pointer_offset),
		.request_size   (request_size),
		.status         (status),
		.result_offset  (result_offset),
		.copy_source    (copy_source),
		.copy_length    (copy_length)
	);

`ifndef SYNTHESIS
	// an accepted item blocks the input until its result is formed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// an unknown pointer leaves no result and no copy range
	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ffha_pkg::ST_UNKNOWN |-> result_offset == '0
		&& copy_length == '0 && copy_source == '0)
		else $error("unknown pointer result carries offsets");

	// a copy range comes only with a successful moving resize
	a_copy_success: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && copy_source != '0 |-> status == ffha_pkg::ST_OK
		&& result_offset != '0)
		else $error("copy range without a new block");
`endif

endmodule

`default_nettype wire

// ===== hdl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory indexed by block address, walk registers,
// split and merge arithmetic and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_dp #(
	parameter int HEAP_BYTES    = 262144,
	parameter int GRANULE_BYTES = 8,
	parameter int HEADER_BYTES  = 24,
	localparam int PW = $clog2(HEAP_BYTES),
	localparam int RW = PW + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ffha_pkg::cmd_t       cmd,
	output ffha_pkg::dp_flags_t       flags,
	input  wire logic [1:0]           action,
	input  wire logic [PW-1:0]        pointer_offset,
	input  wire logic [RW-1:0]        request_size,
	output logic [1:0]                status,
	output logic [PW-1:0]             result_offset,
	output logic [PW-1:0]             copy_source,
	output logic [RW-1:0]             copy_length
);

	localparam int SW    = PW + 1;
	localparam int AW    = PW + 1;
	localparam int XW    = PW + 2;
	localparam int GB    = $clog2(GRANULE_BYTES);
	localparam int DEPTH = HEAP_BYTES / GRANULE_BYTES;
	localparam int IW    = $clog2(DEPTH);

	localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
	localparam logic [XW-1:0] GR_X   = XW'(GRANULE_BYTES);
	localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
	localparam logic [SW:0]   RESET_WORD = {SW'(HEAP_BYTES - HEADER_BYTES), 1'b1};

	// latched item and walk state
	logic [1:0]    action_q;
	logic [PW-1:0] ptr_q;
	logic [RW-1:0] req_q;
	logic [XW-1:0] need_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] prev_addr_q;
	logic [SW-1:0] prev_size_q;
	logic          prev_free_q;
	logic [SW-1:0] cur_size_q;
	logic [SW-1:0] take_size_q;
	logic [SW-1:0] nxt_size_q;
	logic          nxt_free_q;
	logic [PW-1:0] take_off_q;

	// result registers
	logic [1:0]    status_q;
	logic [PW-1:0] result_q;
	logic [PW-1:0] csrc_q;
	logic [RW-1:0] clen_q;

	// header memory
	logic [SW:0]   hdr_mem [DEPTH];
	logic [SW:0]   mem_q;
	logic          valid0_q;
	logic          rd_init_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [SW:0]   wdata;
	logic          re;
	logic [IW-1:0] raddr;

	logic [SW:0]   rword;
	logic [SW-1:0] rsize;
	logic          rfree;
	logic [XW-1:0] walk_next;
	logic [XW-1:0] next_addr;
	logic [XW-1:0] split_addr;
	logic [XW-1:0] merge_size;
	logic [AW-1:0] merge_start;
	logic [XW-1:0] need_in;
	logic          split;

	// header read back, entry zero reads as the reset block until written
	assign rword = rd_init_q ? RESET_WORD : mem_q;
	assign rsize = rword[SW:1];
	assign rfree = rword[0];

	// address arithmetic
	assign walk_next  = XW'(addr_q) + HDR_X + XW'(rsize);
	assign next_addr  = XW'(addr_q) + HDR_X + XW'(cur_size_q);
	assign split_addr = XW'(addr_q) + HDR_X + need_q;
	assign split      = XW'(take_size_q) >= need_q + HDR_X + GR_X;
	assign need_in    = ((XW'(request_size) + GR_X - XW'(1)) >> GB) << GB;

	// merged free block covers previous, current and next where free
	assign merge_start = prev_free_q ? prev_addr_q : addr_q;
	assign merge_size  = (prev_free_q ? XW'(prev_size_q) + HDR_X : '0) + XW'(cur_size_q)
		+ (nxt_free_q ? HDR_X + XW'(nxt_size_q) : '0);

	// status to the controller
	always_comb begin
		flags.act      = action_q;
		flags.req_zero = (req_q == '0);
		flags.ptr_zero = (ptr_q == '0);
		flags.at_end   = (XW'(addr_q) >= HEAP_X);
		flags.hit      = (XW'(addr_q) + HDR_X == XW'(ptr_q));
		flags.rd_free  = rfree;
		flags.fits     = rfree && (XW'(rsize) >= need_q);
		flags.keep     = (XW'(rsize) >= XW'(req_q));
		flags.split    = split;
		flags.next_end = (next_addr >= HEAP_X);
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = addr_q[GB +: IW];
		wdata = {take_size_q, 1'b0};
		re    = 1'b0;
		raddr = addr_q[GB +: IW];
		case (cmd.op)
			ffha_pkg::OP_READ_WALK: begin
				re = 1'b1;
			end
			ffha_pkg::OP_READ_NEXT: begin
				re    = 1'b1;
				raddr = next_addr[GB +: IW];
			end
			ffha_pkg::OP_WRITE_MERGE: begin
				we    = 1'b1;
				waddr = merge_start[GB +: IW];
				wdata = {merge_size[SW-1:0], 1'b1};
			end
			ffha_pkg::OP_WRITE_TAKE: begin
				we    = 1'b1;
				wdata = {split ? need_q[SW-1:0] : take_size_q, 1'b0};
			end
			ffha_pkg::OP_WRITE_SPLIT: begin
				we    = 1'b1;
				waddr = split_addr[GB +: IW];
				wdata = {SW'(XW'(take_size_q) - need_q - HDR_X), 1'b1};
			end
			default: begin
			end
		endcase
	end

	// header memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem[waddr] <= wdata;
		end
		if (re) begin
			mem_q <= hdr_mem[raddr];
		end
	end

	// entry zero written flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q  <= 1'b0;
			rd_init_q <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				valid0_q <= 1'b1;
			end
			if (re) begin
				rd_init_q <= (raddr == '0) && !valid0_q;
			end
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_LOAD: begin
				action_q <= action;
				ptr_q    <= pointer_offset;
				req_q    <= request_size;
				need_q   <= need_in;
			end
			ffha_pkg::OP_WALK_INIT: begin
				addr_q      <= '0;
				prev_free_q <= 1'b0;
			end
			ffha_pkg::OP_STEP: begin
				prev_addr_q <= addr_q;
				prev_size_q <= rsize;
				prev_free_q <= rfree;
				addr_q      <= walk_next[AW-1:0];
			end
			ffha_pkg::OP_LATCH_CUR: begin
				cur_size_q <= rsize;
			end
			ffha_pkg::OP_LATCH_TAKE: begin
				take_size_q <= rsize;
			end
			ffha_pkg::OP_CLEAR_NEXT: begin
				nxt_free_q <= 1'b0;
			end
			ffha_pkg::OP_LATCH_NEXT: begin
				nxt_free_q <= rfree;
				nxt_size_q <= rsize;
			end
			ffha_pkg::OP_WRITE_TAKE: begin
				take_off_q <= PW'(XW'(addr_q) + HDR_X);
			end
			ffha_pkg::OP_FINISH: begin
				status_q <= cmd.st;
				case (cmd.sel)
					ffha_pkg::RES_PTR:  result_q <= ptr_q;
					ffha_pkg::RES_TAKE: result_q <= take_off_q;
					default:            result_q <= '0;
				endcase
				csrc_q <= cmd.copy ? ptr_q : '0;
				clen_q <= cmd.copy ? cur_size_q : '0;
			end
			default: begin
			end
		endcase
	end

	assign status        = status_q;
	assign result_offset = result_q;
	assign copy_source   = csrc_q;
	assign copy_length   = clen_q;

endmodule

`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences lookup, first-fit search, split, release with
// merge, and the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire ffha_pkg::dp_flags_t flags,
	output ffha_pkg::cmd_t           cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_FIND_INIT,
		S_FIND_RD,
		S_FIND_EV,
		S_TAKE_INIT,
		S_TAKE_RD,
		S_TAKE_EV,
		S_TAKE_WR,
		S_SPLIT_WR,
		S_REL_NRD,
		S_REL_NEV,
		S_REL_WR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_ALLOC,
		PH_FREE,
		PH_RESIZE,
		PH_REFIND
	} phase_t;

	state_t             state_q;
	phase_t             phase_q;
	ffha_pkg::status_t  fin_st_q;
	ffha_pkg::res_sel_t fin_sel_q;
	logic               fin_copy_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// datapath command for the current state
	always_comb begin
		cmd.op   = ffha_pkg::OP_NONE;
		cmd.st   = fin_st_q;
		cmd.sel  = fin_sel_q;
		cmd.copy = fin_copy_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) cmd.op = ffha_pkg::OP_LOAD;
			S_DECIDE:    cmd.op = ffha_pkg::OP_NONE;
			S_FIND_INIT: cmd.op = ffha_pkg::OP_WALK_INIT;
			S_TAKE_INIT: cmd.op = ffha_pkg::OP_WALK_INIT;
			S_FIND_RD:   if (!flags.at_end) cmd.op = ffha_pkg::OP_READ_WALK;
			S_TAKE_RD:   if (!flags.at_end) cmd.op = ffha_pkg::OP_READ_WALK;
			S_FIND_EV: begin
				if (!flags.hit) begin
					cmd.op = ffha_pkg::OP_STEP;
				end else if (!flags.rd_free) begin
					cmd.op = ffha_pkg::OP_LATCH_CUR;
				end
			end
			S_TAKE_EV:   cmd.op = flags.fits ? ffha_pkg::OP_LATCH_TAKE : ffha_pkg::OP_STEP;
			S_TAKE_WR:   cmd.op = ffha_pkg::OP_WRITE_TAKE;
			S_SPLIT_WR:  cmd.op = ffha_pkg::OP_WRITE_SPLIT;
			S_REL_NRD:   cmd.op = flags.next_end ? ffha_pkg::OP_CLEAR_NEXT
				: ffha_pkg::OP_READ_NEXT;
			S_REL_NEV:   cmd.op = ffha_pkg::OP_LATCH_NEXT;
			S_REL_WR:    cmd.op = ffha_pkg::OP_WRITE_MERGE;
			S_DONE:      if (slot_free) cmd.op = ffha_pkg::OP_FINISH;
			default:     cmd.op = ffha_pkg::OP_NONE;
		endcase
	end

	// state, phase, pending result and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_ALLOC;
			fin_st_q    <= ffha_pkg::ST_OK;
			fin_sel_q   <= ffha_pkg::RES_ZERO;
			fin_copy_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					fin_st_q   <= ffha_pkg::ST_OK;
					fin_sel_q  <= ffha_pkg::RES_ZERO;
					fin_copy_q <= 1'b0;
					if (flags.act == ffha_pkg::ACT_ALLOC
						|| (flags.act == ffha_pkg::ACT_RESIZE && flags.ptr_zero)) begin
						if (flags.req_zero) begin
							fin_st_q <= ffha_pkg::ST_NULL;
							state_q  <= S_DONE;
						end else begin
							phase_q <= PH_ALLOC;
							state_q <= S_TAKE_INIT;
						end
					end else if (flags.act == ffha_pkg::ACT_FREE) begin
						if (flags.ptr_zero) begin
							state_q <= S_DONE;
						end else begin
							phase_q <= PH_FREE;
							state_q <= S_FIND_INIT;
						end
					end else if (flags.act == ffha_pkg::ACT_RESIZE) begin
						phase_q <= PH_RESIZE;
						state_q <= S_FIND_INIT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FIND_INIT: state_q <= S_FIND_RD;
				S_FIND_RD: begin
					if (flags.at_end) begin
						if (phase_q != PH_REFIND) fin_st_q <= ffha_pkg::ST_UNKNOWN;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FIND_EV;
					end
				end
				S_FIND_EV: begin
					if (!flags.hit) begin
						state_q <= S_FIND_RD;
					end else if (flags.rd_free) begin
						// pointer names a free block
						if (phase_q != PH_REFIND) fin_st_q <= ffha_pkg::ST_UNKNOWN;
						state_q <= S_DONE;
					end else if (phase_q == PH_RESIZE) begin
						if (flags.req_zero) begin
							fin_st_q <= ffha_pkg::ST_NULL;
							state_q  <= S_REL_NRD;
						end else if (flags.keep) begin
							fin_sel_q <= ffha_pkg::RES_PTR;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_TAKE_INIT;
						end
					end else begin
						state_q <= S_REL_NRD;
					end
				end
				S_TAKE_INIT: state_q <= S_TAKE_RD;
				S_TAKE_RD: begin
					if (flags.at_end) begin
						fin_st_q <= ffha_pkg::ST_NULL;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_TAKE_EV;
					end
				end
				S_TAKE_EV: state_q <= flags.fits ? S_TAKE_WR : S_TAKE_RD;
				S_TAKE_WR, S_SPLIT_WR: begin
					if (state_q == S_TAKE_WR && flags.split) begin
						state_q <= S_SPLIT_WR;
					end else begin
						fin_sel_q <= ffha_pkg::RES_TAKE;
						if (phase_q == PH_RESIZE) begin
							// moving resize: look up the old block again and release it
							fin_copy_q <= 1'b1;
							phase_q    <= PH_REFIND;
							state_q    <= S_FIND_INIT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_REL_NRD: state_q <= flags.next_end ? S_REL_WR : S_REL_NEV;
				S_REL_NEV: state_q <= S_REL_WR;
				S_REL_WR:  state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// output valid rises with a new result and drops once the result is taken
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/first_fit_heap_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_tb
// Drives allocate, free and resize items into the allocator, predicts each
// result with a behavioral copy of the block chain and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_tb;

	localparam int HEAP = 262144;
	localparam int GRAN = 8;
	localparam int HDR = 24;
	localparam int MAXB = HEAP / (HDR + GRAN) + 1;
	localparam int WATCHDOG = 400000;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  st;
		logic [17:0] res;
		logic [17:0] src;
		logic [18:0] len;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] action = '0;
	logic [17:0] pointer_offset = '0;
	logic [18:0] request_size = '0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid;
	logic [1:0] status;
	logic [17:0] result_offset, copy_source;
	logic [18:0] copy_length;

	first_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .pointer_offset(pointer_offset),
		.request_size(request_size), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .result_offset(result_offset),
		.copy_source(copy_source), .copy_length(copy_length)
	);

	always #6 clk = ~clk;

	// predicted heap: block payload sizes and free marks in address order
	int unsigned blk_size[MAXB];
	bit blk_free[MAXB];
	int unsigned blk_count;
	alloc_result_t expected_results[$];
	int unsigned live_ptrs[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	int send_gap_pct = 8;
	int recv_stall_pct = 59;

	function automatic int find_alloc(int unsigned ptr);
		int unsigned a;
		a = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (a + HDR == ptr) return blk_free[i] ? -1 : i;
			a += HDR + blk_size[i];
		end
		return -1;
	endfunction

	function automatic bit first_fit(int unsigned req, output int unsigned off);
		int unsigned need, a;
		need = ((req + GRAN - 1) / GRAN) * GRAN;
		a = 0;
		off = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_size[i] >= need) begin
				if (blk_size[i] >= need + HDR + GRAN && blk_count < MAXB) begin
					for (int j = blk_count; j > i + 1; j--) begin
						blk_size[j] = blk_size[j-1];
						blk_free[j] = blk_free[j-1];
					end
					blk_size[i+1] = blk_size[i] - need - HDR;
					blk_free[i+1] = 1;
					blk_size[i] = need;
					blk_count++;
				end
				blk_free[i] = 0;
				off = a + HDR;
				return 1;
			end
			a += HDR + blk_size[i];
		end
		return 0;
	endfunction

	function automatic void release_block(int idx);
		int i;
		blk_free[idx] = 1;
		i = 0;
		while (i + 1 < blk_count) begin
			if (blk_free[i] && blk_free[i+1]) begin
				blk_size[i] += HDR + blk_size[i+1];
				for (int j = i + 1; j + 1 < blk_count; j++) begin
					blk_size[j] = blk_size[j+1];
					blk_free[j] = blk_free[j+1];
				end
				blk_count--;
			end else begin
				i++;
			end
		end
	endfunction

	function automatic alloc_result_t predict_heap_op(logic [1:0] act, int unsigned ptr,
			int unsigned req);
		alloc_result_t r;
		int idx;
		int unsigned off, old;
		r = '0;
		if (act == ffha_pkg::ACT_ALLOC || (act == ffha_pkg::ACT_RESIZE && ptr == 0)) begin
			if (req == 0 || !first_fit(req, off)) r.st = ffha_pkg::ST_NULL;
			else r.res = 18'(off);
		end else if (act == ffha_pkg::ACT_FREE) begin
			if (ptr != 0) begin
				idx = find_alloc(ptr);
				if (idx < 0) r.st = ffha_pkg::ST_UNKNOWN;
				else release_block(idx);
			end
		end else if (act == ffha_pkg::ACT_RESIZE) begin
			idx = find_alloc(ptr);
			if (idx < 0) begin
				r.st = ffha_pkg::ST_UNKNOWN;
			end else if (req == 0) begin
				release_block(idx);
				r.st = ffha_pkg::ST_NULL;
			end else if (blk_size[idx] >= req) begin
				r.res = 18'(ptr);
			end else begin
				old = blk_size[idx];
				if (!first_fit(req, off)) begin
					r.st = ffha_pkg::ST_NULL;
				end else begin
					idx = find_alloc(ptr);
					if (idx >= 0) release_block(idx);
					r.res = 18'(off);
					r.src = 18'(ptr);
					r.len = 19'(old);
				end
			end
		end
		return r;
	endfunction

	// keep a list of live payload offsets to steer frees and resizes
	function automatic void track_live(logic [1:0] act, int unsigned ptr, int unsigned req,
			alloc_result_t r);
		if (ptr != 0 && r.st != ffha_pkg::ST_UNKNOWN && (act == ffha_pkg::ACT_FREE
				|| (act == ffha_pkg::ACT_RESIZE && (r.st == ffha_pkg::ST_OK || req == 0))))
			foreach (live_ptrs[i])
				if (live_ptrs[i] == ptr) begin
					live_ptrs.delete(i);
					break;
				end
		if ((act == ffha_pkg::ACT_ALLOC || act == ffha_pkg::ACT_RESIZE)
				&& r.st == ffha_pkg::ST_OK && r.res != 0) begin
			foreach (live_ptrs[i])
				if (live_ptrs[i] == 32'(r.res)) begin
					live_ptrs.delete(i);
					break;
				end
			live_ptrs.push_back(32'(r.res));
		end
	endfunction

	task automatic send_item(logic [1:0] act, logic [17:0] ptr, logic [18:0] req);
		alloc_result_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pointer_offset <= ptr;
		request_size <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = predict_heap_op(act, 32'(ptr), 32'(req));
		track_live(act, 32'(ptr), 32'(req), r);
		expected_results.push_back(r);
	endtask

	// receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d", status);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st || result_offset !== e.res || copy_source !== e.src ||
						copy_length !== e.len) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							e.st, e.res, e.src, e.len, status, result_offset,
							copy_source, copy_length);
				end
			end
		end
	end

	// watchdog on cycles with no accepted item and no taken result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [17:0] pick_live();
		if (live_ptrs.size() == 0) return 18'(HDR);
		return 18'(live_ptrs[$urandom_range(live_ptrs.size() - 1)]);
	endfunction

	task automatic test_directed();
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd0);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd262144);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'h7FFFF);
		send_item(ffha_pkg::ACT_FREE, 18'd0, 19'd0);
		send_item(ffha_pkg::ACT_FREE, 18'h3FFFF, 19'd0);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd1);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd8);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd13);
		send_item(ffha_pkg::ACT_FREE, 18'd25, 19'd0);
		send_item(ffha_pkg::ACT_RESIZE, 18'd24, 19'd5);
		send_item(ffha_pkg::ACT_RESIZE, 18'd24, 19'd100);
		send_item(ffha_pkg::ACT_FREE, 18'd24, 19'd0);
		send_item(ffha_pkg::ACT_RESIZE, 18'd0, 19'd40);
		send_item(ffha_pkg::ACT_RESIZE, pick_live(), 19'd0);
		send_item(ffha_pkg::ACT_RESIZE, 18'd24, 19'd0);
		send_item(ACT_SPARE, 18'h3FFFF, 19'h7FFFF);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd262112);
		send_item(ffha_pkg::ACT_ALLOC, 18'd0, 19'd262144 - 19'd24 - 19'd300);
		send_item(ffha_pkg::ACT_RESIZE, pick_live(), 19'd262000);
		while (live_ptrs.size() > 0) send_item(ffha_pkg::ACT_FREE, pick_live(), 19'd0);
	endtask

	task automatic test_random(int count);
		int k;
		logic [18:0] req;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 3) req = 19'($urandom);
			else if (k < 10) req = 19'($urandom_range(262144, 60000));
			else req = 19'($urandom_range(4000));
			k = $urandom_range(99);
			if (k < 40) send_item(ffha_pkg::ACT_ALLOC, 18'd0, req);
			else if (k < 65) send_item(ffha_pkg::ACT_FREE, pick_live(), 19'd0);
			else if (k < 85) send_item(ffha_pkg::ACT_RESIZE, pick_live(), req);
			else if (k < 92) send_item(ffha_pkg::ACT_FREE, 18'($urandom), 19'd0);
			else if (k < 97) send_item(ffha_pkg::ACT_RESIZE, 18'($urandom), req);
			else send_item(ACT_SPARE, 18'($urandom), req);
		end
	endtask

	initial begin
		blk_size[0] = HEAP - HDR;
		blk_free[0] = 1;
		blk_count = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(170);
		send_gap_pct = 59;
		recv_stall_pct = 8;
		test_random(170);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random(170);
		in_valid <= 1'b0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ffha_pkg.sv
hdl/ffha_dp.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator_top.sv
tb/first_fit_heap_allocator_top_tb.sv
